>>> hdl/mbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared widths, modulus constants and the structs that pass between the
// table builder, the modular multiplier and the top level.
// ----------------------------------------------------------------------------
package mbc_pkg;

    localparam int N_W   = 12;    // width of the upper argument
    localparam int K_W   = 13;    // width of the lower argument, two's complement
    localparam int VAL_W = 30;    // width of a residue

    localparam logic [VAL_W-1:0] PRIME     = 30'd998244353;
    localparam logic [VAL_W-1:0] PRIME_EXP = PRIME - 30'd2;  // Fermat inverse exponent
    localparam logic [31:0]      PRIME_W   = 32'd998244353;
    localparam logic [31:0]      TWO_PRIME = 32'd1996488706;

    // Barrett factor floor(2^60 / p); fits in 31 bits
    localparam logic [63:0] BARRETT_FULL = (64'd1 << 60) / 64'd998244353;
    localparam logic [30:0] BARRETT_M    = BARRETT_FULL[30:0];

    // register stages through the modular multiplier
    localparam int MUL_LAT = 5;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             fact_we;
        logic             inv_we;
        logic [VAL_W-1:0] data;
    } t_tab_wr;

    // side-band that rides through the first multiplier
    typedef struct packed {
        logic             query;
        logic             zero;
        logic [VAL_W-1:0] inv_nk;
    } t_q_tag;

endpackage
`default_nettype wire

>>> hdl/mbc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hdl/mbc_mulmod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_mulmod
// Pipelined a*b mod p with Barrett reduction, five register stages,
// one operation per cycle, with a side-band tag carried alongside.
// ----------------------------------------------------------------------------
module mbc_mulmod #(
    parameter int TAG_W = 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [mbc_pkg::VAL_W-1:0] i_a,
    input  wire logic [mbc_pkg::VAL_W-1:0] i_b,
    input  wire logic [TAG_W-1:0]          i_tag,
    output logic                           o_valid,
    output logic      [mbc_pkg::VAL_W-1:0] o_res,
    output logic      [TAG_W-1:0]          o_tag
);

    logic [mbc_pkg::MUL_LAT-1:0] r_vld;
    logic [TAG_W-1:0]            r_tag [mbc_pkg::MUL_LAT];

    logic [59:0]               r_prod;
    logic [61:0]               r_q2;
    logic [31:0]               r_lo2;
    logic [31:0]               r_lo3;
    logic [31:0]               r_qp3;
    logic [31:0]               r_rem4;
    logic [mbc_pkg::VAL_W-1:0] r_res5;

    logic [59:0] w_prod;
    logic [61:0] w_q2;
    logic [61:0] w_qp;
    logic [31:0] w_fold;

    assign w_prod = 60'(i_a) * 60'(i_b);
    assign w_q2   = 62'(r_prod[59:29]) * 62'(mbc_pkg::BARRETT_M);
    assign w_qp   = 62'(r_q2[61:31]) * 62'(mbc_pkg::PRIME);

    // remainder is below 3p: fold once or twice
    always_comb begin
        if (r_rem4 >= mbc_pkg::TWO_PRIME) begin
            w_fold = r_rem4 - mbc_pkg::TWO_PRIME;
        end else if (r_rem4 >= mbc_pkg::PRIME_W) begin
            w_fold = r_rem4 - mbc_pkg::PRIME_W;
        end else begin
            w_fold = r_rem4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[mbc_pkg::MUL_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        for (int s = 1; s < mbc_pkg::MUL_LAT; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
        r_prod <= w_prod;
        r_q2   <= w_q2;
        r_lo2  <= r_prod[31:0];
        r_qp3  <= w_qp[31:0];
        r_lo3  <= r_lo2;
        r_rem4 <= r_lo3 - r_qp3;
        r_res5 <= w_fold[mbc_pkg::VAL_W-1:0];
    end

    assign o_valid = r_vld[mbc_pkg::MUL_LAT-1];
    assign o_res   = r_res5;
    assign o_tag   = r_tag[mbc_pkg::MUL_LAT-1];

endmodule
`default_nettype wire

>>> hdl/mbc_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_builder
// Post-reset sequencer: fills the factorial table, inverts the last
// factorial by square and multiply, then fills inverse factorials downward.
// ----------------------------------------------------------------------------
module mbc_builder #(
    parameter int TABLE_SIZE = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_mul_valid,
    input  wire logic [mbc_pkg::VAL_W-1:0]         i_mul_res,
    output logic                                   o_busy,
    output logic      [$clog2(TABLE_SIZE)-1:0]     o_wr_addr,
    output mbc_pkg::t_tab_wr                       o_wr,
    output mbc_pkg::t_mul_req                      o_mul
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

    typedef enum logic [3:0] {
        ST_FACT = 4'b0001,
        ST_POW  = 4'b0010,
        ST_INV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_bld_state;

    t_bld_state                r_state, n_state;
    logic [AW-1:0]             r_idx,   n_idx;
    logic [mbc_pkg::VAL_W-1:0] r_val,   n_val;
    logic [mbc_pkg::VAL_W-1:0] r_acc,   n_acc;
    logic [mbc_pkg::VAL_W-1:0] r_base,  n_base;
    logic [mbc_pkg::VAL_W-1:0] r_exp,   n_exp;
    logic                      r_pend,  n_pend;
    logic                      r_phase, n_phase;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_val   = r_val;
        n_acc   = r_acc;
        n_base  = r_base;
        n_exp   = r_exp;
        n_pend  = r_pend;
        n_phase = r_phase;
        o_wr    = '0;
        o_mul   = '0;
        case (r_state)
            ST_FACT: begin
                if (!r_pend) begin
                    o_wr.fact_we = 1'b1;
                    o_wr.data    = r_val;
                    if (r_idx == LAST) begin
                        n_state = ST_POW;
                        n_base  = r_val;
                        n_acc   = 30'd1;
                        n_exp   = mbc_pkg::PRIME_EXP;
                        n_phase = 1'b0;
                    end else begin
                        o_mul.valid = 1'b1;
                        o_mul.a     = r_val;
                        o_mul.b     = mbc_pkg::VAL_W'(r_idx) + 30'd1;
                        n_pend      = 1'b1;
                        n_idx       = r_idx + AW'(1);
                    end
                end else if (i_mul_valid) begin
                    n_val  = i_mul_res;
                    n_pend = 1'b0;
                end
            end
            ST_POW: begin
                if (!r_pend) begin
                    if (r_exp == '0) begin
                        n_state = ST_INV;
                        n_val   = r_acc;
                    end else begin
                        // phase 0: acc*base, phase 1: base*base
                        o_mul.valid = 1'b1;
                        o_mul.a     = r_phase ? r_base : r_acc;
                        o_mul.b     = r_base;
                        n_pend      = 1'b1;
                    end
                end else if (i_mul_valid) begin
                    n_pend = 1'b0;
                    if (!r_phase) begin
                        if (r_exp[0]) begin
                            n_acc = i_mul_res;
                        end
                        n_phase = 1'b1;
                    end else begin
                        n_base  = i_mul_res;
                        n_exp   = r_exp >> 1;
                        n_phase = 1'b0;
                    end
                end
            end
            ST_INV: begin
                if (!r_pend) begin
                    o_wr.inv_we = 1'b1;
                    o_wr.data   = r_val;
                    if (r_idx == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        o_mul.valid = 1'b1;
                        o_mul.a     = r_val;
                        o_mul.b     = mbc_pkg::VAL_W'(r_idx);
                        n_pend      = 1'b1;
                        n_idx       = r_idx - AW'(1);
                    end
                end else if (i_mul_valid) begin
                    n_val  = i_mul_res;
                    n_pend = 1'b0;
                end
            end
            ST_DONE: begin
            end
            default: begin
                n_state = ST_FACT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FACT;
            r_idx   <= '0;
            r_val   <= 30'd1;
            r_pend  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_val   <= n_val;
            r_pend  <= n_pend;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_base <= n_base;
        r_exp  <= n_exp;
    end

    assign o_busy    = (r_state != ST_DONE);
    assign o_wr_addr = r_idx;

endmodule
`default_nettype wire

>>> hdl/modular_binomial_coefficient.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modular_binomial_coefficient
// C(n, k) mod 998244353 from factorial and inverse-factorial tables.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a query (i_n, i_k) transfers on a rising edge where
//   start is high and busy is low. One query may transfer every cycle.
//   Result channel: o_value is presented for one cycle with o_valid high,
//   after the query passes the decode register, the table read register,
//   two five-stage modular multipliers and one output register. Results leave
//   in query order; the receiver cannot stall, so the pipeline never holds.
//   A negative k, k above n, or n outside the table gives zero.
// Reset:
//   After reset busy stays high while the tables are built. Every build step
//   goes through the shared multiplier and waits for its result before the
//   next one is issued, through the two table fills and the Fermat inverse
//   (sixty multiplies). The multiplier round trip sets the build time.
//   Throughput after build is one query per cycle, set by the single
//   read port per table copy and the fully pipelined multipliers.
// ----------------------------------------------------------------------------
module modular_binomial_coefficient #(
    parameter int TABLE_SIZE = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic        [mbc_pkg::N_W-1:0]   i_n,
    input  wire logic signed [mbc_pkg::K_W-1:0]   i_k,
    output logic                                  o_valid,
    output logic             [mbc_pkg::VAL_W-1:0] o_value
);

    localparam int AW = $clog2(TABLE_SIZE);
    // wide enough for both an argument and a table index
    localparam int QW = (AW > mbc_pkg::N_W) ? AW : mbc_pkg::N_W;
    localparam logic [QW:0] TS_LIM = (QW + 1)'(TABLE_SIZE);
    localparam int LATENCY = 2 * mbc_pkg::MUL_LAT + 3;

    // builder
    logic              w_bld_busy;
    logic [AW-1:0]     w_bld_addr;
    mbc_pkg::t_tab_wr  w_bld_wr;
    mbc_pkg::t_mul_req w_bld_mul;

    // stage 1: decoded query
    logic          r_s1_valid;
    logic          r_s1_zero;
    logic [AW-1:0] r_s1_addr_n;
    logic [AW-1:0] r_s1_addr_k;
    logic [AW-1:0] r_s1_addr_nk;

    logic [mbc_pkg::N_W-1:0] w_k_mag;
    logic [mbc_pkg::N_W-1:0] w_nk;
    logic [QW-1:0]           w_n_ext;
    logic [QW-1:0]           w_k_ext;
    logic [QW-1:0]           w_nk_ext;
    logic                    w_zero;
    logic                    w_accept;

    // stage 2: table data
    logic                      r_s2_valid;
    logic                      r_s2_zero;
    logic [mbc_pkg::VAL_W-1:0] w_fact;
    logic [mbc_pkg::VAL_W-1:0] w_inv_k;
    logic [mbc_pkg::VAL_W-1:0] w_inv_nk;

    // multipliers
    logic                      w_m1_valid;
    logic [mbc_pkg::VAL_W-1:0] w_m1_a;
    logic [mbc_pkg::VAL_W-1:0] w_m1_b;
    mbc_pkg::t_q_tag           w_m1_tag;
    logic                      w_m1_out_valid;
    logic [mbc_pkg::VAL_W-1:0] w_m1_res;
    mbc_pkg::t_q_tag           w_m1_out_tag;
    logic                      w_m2_valid;
    logic                      w_m2_out_valid;
    logic [mbc_pkg::VAL_W-1:0] w_m2_res;
    logic                      w_m2_zero;

    // output register
    logic                      r_out_valid;
    logic [mbc_pkg::VAL_W-1:0] r_out_value;

    // ------------------------------------------------------------------
    // Table builder
    // ------------------------------------------------------------------
    mbc_builder #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_builder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mul_valid (w_m1_out_valid && !w_m1_out_tag.query),
        .i_mul_res   (w_m1_res),
        .o_busy      (w_bld_busy),
        .o_wr_addr   (w_bld_addr),
        .o_wr        (w_bld_wr),
        .o_mul       (w_bld_mul)
    );

    assign busy     = w_bld_busy;
    assign w_accept = start && !w_bld_busy;

    // ------------------------------------------------------------------
    // Stage 1: range check and table addresses
    // ------------------------------------------------------------------
    assign w_k_mag  = i_k[mbc_pkg::N_W-1:0];
    assign w_nk     = i_n - w_k_mag;
    assign w_n_ext  = QW'(i_n);
    assign w_k_ext  = QW'(w_k_mag);
    assign w_nk_ext = QW'(w_nk);
    // zero for negative k, k above n, or n past the table end
    assign w_zero   = i_k[mbc_pkg::K_W-1] || (w_k_mag > i_n) || ({1'b0, w_n_ext} >= TS_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_zero    <= w_zero;
        r_s1_addr_n  <= w_n_ext[AW-1:0];
        r_s1_addr_k  <= w_k_ext[AW-1:0];
        r_s1_addr_nk <= w_nk_ext[AW-1:0];
        r_s2_zero    <= r_s1_zero;
    end

    // ------------------------------------------------------------------
    // Stage 2: table reads; inverse table kept in two copies, one per port
    // ------------------------------------------------------------------
    mbc_ram #(
        .WIDTH (mbc_pkg::VAL_W),
        .DEPTH (TABLE_SIZE)
    ) u_fact_ram (
        .i_clk   (i_clk),
        .i_we    (w_bld_wr.fact_we),
        .i_waddr (w_bld_addr),
        .i_wdata (w_bld_wr.data),
        .i_raddr (r_s1_addr_n),
        .o_rdata (w_fact)
    );

    mbc_ram #(
        .WIDTH (mbc_pkg::VAL_W),
        .DEPTH (TABLE_SIZE)
    ) u_inv_k_ram (
        .i_clk   (i_clk),
        .i_we    (w_bld_wr.inv_we),
        .i_waddr (w_bld_addr),
        .i_wdata (w_bld_wr.data),
        .i_raddr (r_s1_addr_k),
        .o_rdata (w_inv_k)
    );

    mbc_ram #(
        .WIDTH (mbc_pkg::VAL_W),
        .DEPTH (TABLE_SIZE)
    ) u_inv_nk_ram (
        .i_clk   (i_clk),
        .i_we    (w_bld_wr.inv_we),
        .i_waddr (w_bld_addr),
        .i_wdata (w_bld_wr.data),
        .i_raddr (r_s1_addr_nk),
        .o_rdata (w_inv_nk)
    );

    // ------------------------------------------------------------------
    // First multiplier: shared with the builder while busy,
    // fact[n] * invfact[k] afterwards
    // ------------------------------------------------------------------
    always_comb begin
        if (w_bld_busy) begin
            w_m1_valid = w_bld_mul.valid;
            w_m1_a     = w_bld_mul.a;
            w_m1_b     = w_bld_mul.b;
            w_m1_tag   = '0;
        end else begin
            w_m1_valid      = r_s2_valid;
            w_m1_a          = w_fact;
            w_m1_b          = w_inv_k;
            w_m1_tag.query  = 1'b1;
            w_m1_tag.zero   = r_s2_zero;
            w_m1_tag.inv_nk = w_inv_nk;
        end
    end

    mbc_mulmod #(
        .TAG_W ($bits(mbc_pkg::t_q_tag))
    ) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m1_valid),
        .i_a     (w_m1_a),
        .i_b     (w_m1_b),
        .i_tag   (w_m1_tag),
        .o_valid (w_m1_out_valid),
        .o_res   (w_m1_res),
        .o_tag   (w_m1_out_tag)
    );

    // ------------------------------------------------------------------
    // Second multiplier: times invfact[n-k]; builder results drop here
    // ------------------------------------------------------------------
    assign w_m2_valid = w_m1_out_valid && w_m1_out_tag.query;

    mbc_mulmod #(
        .TAG_W (1)
    ) u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m2_valid),
        .i_a     (w_m1_res),
        .i_b     (w_m1_out_tag.inv_nk),
        .i_tag   (w_m1_out_tag.zero),
        .o_valid (w_m2_out_valid),
        .o_res   (w_m2_res),
        .o_tag   (w_m2_zero)
    );

    // ------------------------------------------------------------------
    // Output register: force zero for out-of-range queries
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_m2_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= w_m2_zero ? '0 : w_m2_res;
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // every transferred query comes out after the fixed latency
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("query result missing at fixed latency");

    // no result while the tables are still being built
    a_no_early_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result presented while building tables");

    // builder multiplies all retire before queries are taken
    a_builder_drained : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_m1_out_valid && !w_m1_out_tag.query) |-> w_bld_busy)
        else $error("builder multiply result after build finished");

    // the reduction always lands below the modulus
    a_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value < mbc_pkg::PRIME))
        else $error("result not fully reduced");

endmodule
`default_nettype wire
